// File: rtl/core/tempo_clock_divider_with_sync_core_assert.svh
// ----------------------------------------------------------------------------
// Tempo clock divider assertion macros
// Shared forms for the concurrent checks of the tempo clock divider.
// ----------------------------------------------------------------------------
`ifndef TEMPO_CLOCK_DIVIDER_WITH_SYNC_CORE_ASSERT_SVH
`define TEMPO_CLOCK_DIVIDER_WITH_SYNC_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCDWS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tempo clock divider check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCDWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tempo clock divider check failed");

`endif

// File: rtl/core/tcdws_pkg.sv
// ----------------------------------------------------------------------------
// Tempo clock divider package
// Types, codes and constants shared by the core and its checker.
// ----------------------------------------------------------------------------
package tcdws_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_TEMPO = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        LED_OFF        = 2'd0,
        LED_ON         = 2'd1,
        LED_BLINK_SLOW = 2'd2,
        LED_BLINK_FAST = 2'd3
    } led_t;

    typedef enum logic [2:0] {
        RUN_HALTED  = 3'b001,
        RUN_RUNNING = 3'b010,
        RUN_WAITING = 3'b100
    } run_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } seq_t;

    localparam logic [1:0] MODE_FREE     = 2'd0;
    localparam logic [1:0] MODE_START    = 2'd1;
    localparam logic [1:0] MODE_EVERY    = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    localparam logic [9:0]  BPM_MAX       = 10'd600;
    localparam logic [11:0] DUTY_MAX      = 12'd4095;
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    localparam logic [15:0] BEAT_RESET = 16'd600;
    localparam logic [15:0] HIGH_RESET = 16'd300;

    localparam int          STEP_W    = 4;
    localparam logic [3:0]  DIV_LAST  = 4'd15;
    localparam logic [3:0]  MUL_LAST  = 4'd12;

endpackage

// File: rtl/core/tempo_clock_divider_with_sync_core.sv
// ----------------------------------------------------------------------------
// Tempo clock divider with sync input
// Millisecond beat generator with divided gates, run button and sync release.
// ----------------------------------------------------------------------------
// Channel    Direction  Payload
// s_ (in)    slave      tuser: command; tdata: sync_level, tempo_bpm, duty_value
// m_ (out)   master     tdata: gate_div1..gate_div8, led_mode
// cfg_       write      sync_mode
//
// A tick or run press request needs no further steps; its result is
// registered at once. A set tempo request holds s_tready low while the
// core runs 16 restoring division steps, 13 shift-add multiply steps and a
// clamp step. Reset is synchronous and active low. While a result waits on
// m_tready, one further request is taken and its result goes to a skid register.
// ----------------------------------------------------------------------------
module tempo_clock_divider_with_sync_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] sync_level, [10:1] tempo_bpm, [22:11] duty_value, [23] zero
    input  logic [23:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] gate_div1, [1] gate_div2, [2] gate_div4, [3] gate_div8,
    // [5:4] led_mode, [7:6] zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_wdata
);

    logic                   accept;
    logic                   sync_level;
    logic [9:0]             tempo_bpm;
    logic [11:0]            duty_value;
    tcdws_pkg::cmd_t        command;

    logic [1:0]             sync_mode_reg;
    tcdws_pkg::run_t        run_reg, run_next;
    tcdws_pkg::led_t        led_reg, led_next;
    logic [15:0]            ms_reg, ms_next;
    logic [2:0]             beat_idx_reg, beat_idx_next;
    logic [15:0]            beat_len_reg, beat_len_next;
    logic [15:0]            high_len_reg, high_len_next;
    logic [15:0]            high_lat_reg, high_lat_next;
    logic                   last_sync_reg, last_sync_next;
    logic [3:0]             gates_reg, gates_next;

    tcdws_pkg::seq_t        seq_reg, seq_next;
    logic [tcdws_pkg::STEP_W-1:0] step_reg, step_next;
    logic [9:0]             divisor_reg, divisor_next;
    logic [9:0]             rem_reg, rem_next;
    logic [15:0]            quo_reg, quo_next;
    logic [28:0]            prod_reg, prod_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_data_reg, out_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [7:0]             skid_data_reg, skid_data_next;

    logic                   mode_free, mode_start, mode_every;
    logic                   sync_release;
    tcdws_pkg::run_t        run_tick;
    logic [15:0]            ms_base;
    logic [16:0]            ms_inc_wide;
    logic [15:0]            ms_inc;
    logic                   sync_end;
    logic                   beat_wrap;
    logic [15:0]            ms_tick;
    logic [2:0]             beat_idx_tick;
    logic [15:0]            high_lat_tick;
    logic                   gate_on;
    logic [9:0]             bpm_clamped;
    logic [12:0]            duty_plus_one;
    logic [10:0]            div_trial;
    logic                   div_ge;
    logic [16:0]            mul_sum;
    logic [16:0]            high_raw;
    logic [15:0]            high_clamped;
    logic [7:0]             result;

    assign command    = tcdws_pkg::cmd_t'(s_tuser);
    assign sync_level = s_tdata[0];
    assign tempo_bpm  = s_tdata[10:1];
    assign duty_value = s_tdata[22:11];

    assign s_tready = (seq_reg == tcdws_pkg::ST_IDLE) && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign mode_free  = (sync_mode_reg == tcdws_pkg::MODE_FREE);
    assign mode_start = (sync_mode_reg == tcdws_pkg::MODE_START);
    assign mode_every = (sync_mode_reg == tcdws_pkg::MODE_EVERY) ||
                        (sync_mode_reg == tcdws_pkg::MODE_RESERVED);

    // Tick path: sync release, then one millisecond of beat counting.
    assign sync_release  = (run_reg == tcdws_pkg::RUN_WAITING) && !mode_free &&
                           !sync_level && last_sync_reg;
    assign run_tick      = sync_release ? tcdws_pkg::RUN_RUNNING : run_reg;
    assign ms_base       = sync_release ? 16'd0 : ms_reg;
    assign ms_inc_wide   = {1'b0, ms_base} + 17'd1;
    assign ms_inc        = ms_inc_wide[15:0];
    assign sync_end      = (ms_inc_wide == {1'b0, beat_len_reg}) && mode_every;
    assign beat_wrap     = (ms_inc >= beat_len_reg);
    assign ms_tick       = beat_wrap ? 16'd0 : ms_inc;
    assign beat_idx_tick = beat_wrap ? beat_idx_reg + 3'd1 : beat_idx_reg;
    assign high_lat_tick = beat_wrap ? high_len_reg : high_lat_reg;
    assign gate_on       = (ms_tick < high_lat_tick);

    assign bpm_clamped   = (tempo_bpm == 10'd0) ? 10'd1 :
                           (tempo_bpm > tcdws_pkg::BPM_MAX) ? tcdws_pkg::BPM_MAX : tempo_bpm;
    assign duty_plus_one = (duty_value == 12'd0) ? 13'd2 : {1'b0, duty_value} + 13'd1;

    // One restoring division step per cycle in ST_DIV, one shift-add multiply step per cycle in ST_MUL.
    assign div_trial = {rem_reg, quo_reg[15]};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});
    assign mul_sum   = {1'b0, prod_reg[28:13]} + (prod_reg[0] ? {1'b0, quo_reg} : 17'd0);

    assign high_raw     = prod_reg[28:12];
    assign high_clamped = (high_raw == 17'd0) ? 16'd1 :
                          (high_raw >= {1'b0, quo_reg}) ? quo_reg - 16'd1 : high_raw[15:0];

    assign result = {2'b00, led_next, gates_next};

    always_comb begin
        run_next       = run_reg;
        led_next       = led_reg;
        ms_next        = ms_reg;
        beat_idx_next  = beat_idx_reg;
        beat_len_next  = beat_len_reg;
        high_len_next  = high_len_reg;
        high_lat_next  = high_lat_reg;
        last_sync_next = last_sync_reg;
        gates_next     = gates_reg;
        seq_next       = seq_reg;
        step_next      = step_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        prod_next      = prod_reg;

        if (accept) begin
            case (command)
                tcdws_pkg::CMD_TICK: begin
                    last_sync_next = sync_level;
                    run_next       = run_tick;
                    ms_next        = ms_base;
                    if (sync_release) begin
                        led_next = tcdws_pkg::LED_ON;
                    end
                    if (run_tick == tcdws_pkg::RUN_RUNNING) begin
                        if (sync_end) begin
                            ms_next    = 16'd0;
                            run_next   = tcdws_pkg::RUN_WAITING;
                            gates_next = 4'd0;
                        end else begin
                            ms_next       = ms_tick;
                            beat_idx_next = beat_idx_tick;
                            high_lat_next = high_lat_tick;
                            gates_next    = {gate_on && (beat_idx_tick == 3'd0),
                                             gate_on && (beat_idx_tick[1:0] == 2'd0),
                                             gate_on && !beat_idx_tick[0],
                                             gate_on};
                        end
                    end
                end
                tcdws_pkg::CMD_RUN: begin
                    if (run_reg == tcdws_pkg::RUN_HALTED) begin
                        if (mode_free) begin
                            run_next = tcdws_pkg::RUN_RUNNING;
                            led_next = tcdws_pkg::LED_ON;
                        end else if (mode_start) begin
                            beat_idx_next = 3'd0;
                            ms_next       = 16'd0;
                            gates_next    = 4'd0;
                            run_next      = tcdws_pkg::RUN_WAITING;
                            led_next      = tcdws_pkg::LED_BLINK_SLOW;
                        end else begin
                            run_next = tcdws_pkg::RUN_WAITING;
                            led_next = tcdws_pkg::LED_BLINK_FAST;
                        end
                    end else begin
                        run_next = tcdws_pkg::RUN_HALTED;
                        led_next = tcdws_pkg::LED_OFF;
                    end
                end
                tcdws_pkg::CMD_TEMPO: begin
                    divisor_next = bpm_clamped;
                    rem_next     = 10'd0;
                    quo_next     = tcdws_pkg::MS_PER_MINUTE;
                    prod_next    = {16'd0, duty_plus_one};
                    step_next    = '0;
                    seq_next     = tcdws_pkg::ST_DIV;
                end
                default: begin
                end
            endcase
        end

        case (seq_reg)
            tcdws_pkg::ST_IDLE: begin
            end
            tcdws_pkg::ST_DIV: begin
                rem_next  = div_ge ? 10'(div_trial - {1'b0, divisor_reg}) : div_trial[9:0];
                quo_next  = {quo_reg[14:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == tcdws_pkg::DIV_LAST) begin
                    step_next = '0;
                    seq_next  = tcdws_pkg::ST_MUL;
                end
            end
            tcdws_pkg::ST_MUL: begin
                prod_next = {mul_sum, prod_reg[12:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == tcdws_pkg::MUL_LAST) begin
                    seq_next = tcdws_pkg::ST_FIN;
                end
            end
            tcdws_pkg::ST_FIN: begin
                beat_len_next = quo_reg;
                high_len_next = high_clamped;
                seq_next      = tcdws_pkg::ST_IDLE;
            end
            default: begin
                seq_next = tcdws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_mode_reg  <= tcdws_pkg::MODE_FREE;
            run_reg        <= tcdws_pkg::RUN_HALTED;
            led_reg        <= tcdws_pkg::LED_OFF;
            ms_reg         <= 16'd0;
            beat_idx_reg   <= 3'd0;
            beat_len_reg   <= tcdws_pkg::BEAT_RESET;
            high_len_reg   <= tcdws_pkg::HIGH_RESET;
            high_lat_reg   <= tcdws_pkg::HIGH_RESET;
            last_sync_reg  <= 1'b1;
            gates_reg      <= 4'd0;
            seq_reg        <= tcdws_pkg::ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                sync_mode_reg <= cfg_wdata;
            end
            run_reg        <= run_next;
            led_reg        <= led_next;
            ms_reg         <= ms_next;
            beat_idx_reg   <= beat_idx_next;
            beat_len_reg   <= beat_len_next;
            high_len_reg   <= high_len_next;
            high_lat_reg   <= high_lat_next;
            last_sync_reg  <= last_sync_next;
            gates_reg      <= gates_next;
            seq_reg        <= seq_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        divisor_reg   <= divisor_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        prod_reg      <= prod_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: rtl/core/tcdws_checker.sv
// ----------------------------------------------------------------------------
// Tempo clock divider port checker
// Watches the ports of the tempo clock divider and is bound to the core.
// ----------------------------------------------------------------------------
`include "tempo_clock_divider_with_sync_core_assert.svh"

module tcdws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        cfg_wen,
    input logic [1:0]  cfg_wdata
);

    logic tempo_req;
    logic gates_nested;

    assign tempo_req    = s_tvalid && s_tready && (s_tuser == tcdws_pkg::CMD_TEMPO);
    assign gates_nested = (!m_tdata[3] || m_tdata[2]) && (!m_tdata[2] || m_tdata[1]) &&
                          (!m_tdata[1] || m_tdata[0]) && (m_tdata[7:6] == 2'b00);

    // A result that is not taken stays as it is.
    `TCDWS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Every divided gate lies inside the next faster one.
    `TCDWS_ASSERT_SAME(a_gates_nested, aclk, aresetn, m_tvalid, gates_nested)

    // A result only appears after a request was taken.
    `TCDWS_ASSERT_SAME(a_result_cause, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready))

    // The tempo calculation blocks further requests.
    `TCDWS_ASSERT_NEXT(a_tempo_busy, aclk, aresetn, tempo_req, !s_tready)

    logic unused_ok;
    assign unused_ok = &{1'b0, s_tdata[22:0], cfg_wen, cfg_wdata};

endmodule

bind tempo_clock_divider_with_sync_core tcdws_checker u_tcdws_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
);
